[hw/rtl/rms_pkg.sv]
// Shared types and constants for the run merge sorter.
`default_nettype none

package rms_pkg;

  localparam int unsigned VALUE_W          = 32;
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  // Value slot held by one cell of the sorting chain.
  typedef struct packed {
    logic                       valid;
    logic signed [VALUE_W-1:0]  value;
  } rms_slot_t;

  // Chain-wide command, same for every cell in a cycle.
  typedef struct packed {
    logic insert;     // place new value in order
    logic shift_out;  // move everything one cell toward the head
  } rms_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/rms_cell.sv]
// One cell of the sorting chain: holds one value, inserts or shifts.
`default_nettype none

module rms_cell
  import rms_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rms_ctrl_t                 ctrl_i,
  input  logic signed [VALUE_W-1:0] new_value_i,
  input  rms_slot_t                 prev_slot_i,   // neighbor toward the head
  input  logic                      prev_keep_i,   // neighbor keeps its slot
  input  rms_slot_t                 next_slot_i,   // neighbor toward the tail
  output rms_slot_t                 slot_o,
  output logic                      keep_o
);

  logic                      valid_q, valid_d;
  logic signed [VALUE_W-1:0] value_q, value_d;

  // Slot stays in place when it is valid and not larger than the new value.
  assign keep_o = valid_q && (value_q <= new_value_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.shift_out) begin
      valid_d = next_slot_i.valid;
      value_d = next_slot_i.value;
    end else if (ctrl_i.insert && !keep_o) begin
      if (prev_keep_i) begin
        valid_d = 1'b1;
        value_d = new_value_i;
      end else begin
        valid_d = prev_slot_i.valid;
        value_d = prev_slot_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign slot_o = '{valid: valid_q, value: value_q};

endmodule

`default_nettype wire

[hw/rtl/run_merge_sorter_top.sv]
// Top level of the run merge sorter: input control, sorting chain, output register.
//
// Usage:
//   Slave channel s_axis_* carries one signed 32-bit value per beat; tlast marks
//   the final value of a set. Each accepted value is inserted in order into a
//   chain of MAX_ELEMENTS cells in the same cycle, so a value is taken on every
//   beat while no set drains. Values beyond MAX_ELEMENTS in one set are dropped;
//   tlast still ends it. After the tlast beat the chain shifts toward its head
//   one cell per cycle while the output register can take a beat, and the sorted
//   set leaves on m_axis_* in ascending order, tlast on the final beat. The
//   tlast beat sets the drain flag, and from there the head value is loaded into
//   the output register. s_axis_tready_o is low while a set drains. When the
//   receiver stalls, the output register holds its beat and the chain holds still.
//   Reset clears every cell and the element counter; the block starts empty.
`default_nettype none

module run_merge_sorter_top
  import rms_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [VALUE_W-1:0] s_axis_tdata_i,    // [31:0] value
  input  logic               s_axis_tlast_i,    // last
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [VALUE_W-1:0] m_axis_tdata_o,    // [31:0] value_res
  output logic               m_axis_tlast_o     // last_res
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic             drain_q, drain_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;
  logic [VALUE_W-1:0] out_data_q, out_data_d;

  logic      in_beat;
  logic      room;
  logic      load_out;
  rms_ctrl_t ctrl;

  rms_slot_t               slots [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] keeps;
  logic [MAX_ELEMENTS-1:0] valid_vec;

  assign s_axis_tready_o = !drain_q;
  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign room     = (cnt_q < CNT_W'(MAX_ELEMENTS));
  assign load_out = drain_q && (!out_valid_q || m_axis_tready_i);

  assign ctrl.insert    = in_beat && room;
  assign ctrl.shift_out = load_out;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    rms_slot_t prev_slot;
    rms_slot_t next_slot;
    logic      prev_keep;

    if (i == 0) begin : g_head
      assign prev_slot = '0;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_slot = slots[i-1];
      assign prev_keep = keeps[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign next_slot = '0;
    end else begin : g_inner
      assign next_slot = slots[i+1];
    end

    rms_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_value_i (signed'(s_axis_tdata_i)),
      .prev_slot_i (prev_slot),
      .prev_keep_i (prev_keep),
      .next_slot_i (next_slot),
      .slot_o      (slots[i]),
      .keep_o      (keeps[i])
    );

    assign valid_vec[i] = slots[i].valid;
  end

  always_comb begin
    drain_d     = drain_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_beat) begin
      if (room) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (s_axis_tlast_i) begin
        drain_d = 1'b1;
      end
    end

    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = slots[0].value;
      out_last_d  = (cnt_q == CNT_W'(1));
      cnt_d       = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      drain_q     <= drain_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_last_q <= out_last_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // Number of occupied cells always equals the element count.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == cnt_q)
    else $error("cell occupancy differs from element count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> slots[0].valid)
    else $error("draining an empty chain");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("output beat changed while stalled");

endmodule

`default_nettype wire

[verif/run_merge_sorter_checker.sv]
// Checker for the run merge sorter: gathers each set, predicts its sorted order, compares beats.
module run_merge_sorter_checker
  import rms_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [VALUE_W-1:0] s_tdata_i,
  input  logic               s_tlast_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [VALUE_W-1:0] m_tdata_i,
  input  logic               m_tlast_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } sorted_beat_t;

  logic signed [VALUE_W-1:0] set_vals[$];
  sorted_beat_t              sorted_q[$];
  sorted_beat_t              want;
  int                        fails   = 0;
  int                        waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  // Close the current set: order it ascending and queue one beat per kept value.
  task automatic order_set();
    logic signed [VALUE_W-1:0] arr [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0] key;
    sorted_beat_t              b;
    int                        n;
    int                        i;
    int                        j;
    n = set_vals.size();
    for (i = 0; i < n; i++) arr[i] = set_vals[i];
    for (i = 1; i < n; i++) begin
      key = arr[i];
      j = i;
      while (j > 0 && arr[j-1] > key) begin
        arr[j] = arr[j-1];
        j--;
      end
      arr[j] = key;
    end
    for (i = 0; i < n; i++) begin
      b.value = arr[i];
      b.last  = (i == n - 1);
      sorted_q.push_back(b);
    end
    set_vals.delete();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got value %0d last %0b",
                   $time, $signed(m_tdata_i), m_tlast_i);
          fails++;
        end else begin
          want = sorted_q.pop_front();
          if (m_tdata_i !== want.value) begin
            $display("%0t: value mismatch, expected %0d, got %0d",
                     $time, want.value, $signed(m_tdata_i));
            fails++;
          end
          if (m_tlast_i !== want.last) begin
            $display("%0t: last mismatch on value %0d, expected %0b, got %0b",
                     $time, want.value, want.last, m_tlast_i);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        // values past the store depth are dropped, tlast still closes the set
        if (set_vals.size() < MAX_ELEMENTS) set_vals.push_back(s_tdata_i);
        if (s_tlast_i) order_set();
      end
      waiting = sorted_q.size();
    end
  end

endmodule

[verif/run_merge_sorter_top_tb.sv]
// Testbench top for the run merge sorter: clock, reset, stimulus, receiver stalls and verdict.
module run_merge_sorter_top_tb
  import rms_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VAL_ZERO = 32'h0000_0000;
  localparam logic [VALUE_W-1:0] VAL_NEG1 = 32'hffff_ffff;

  localparam int PAT_RANDOM = 0;
  localparam int PAT_ASCEND = 1;
  localparam int PAT_DESCND = 2;
  localparam int PAT_FEWVAL = 3;
  localparam int PAT_CHUNKS = 4;

  localparam int LONG_HOLD_CYCLES = 300;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata  = '0;
  logic               s_tlast  = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [VALUE_W-1:0] m_tdata;
  logic               m_tlast;

  int fails;
  int pending;
  int items_sent = 0;
  bit gaps_on    = 1'b1;
  bit stalls_on  = 1'b1;
  bit long_hold  = 1'b0;

  always #6 clk_i = ~clk_i;

  run_merge_sorter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  run_merge_sorter_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // Offer one beat, possibly after an idle burst, and return once it is taken.
  task automatic push_value(input logic [VALUE_W-1:0] v, input logic l);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    do begin
      @(posedge clk_i);
    end while (!s_tready);
    items_sent++;
  endtask

  task automatic send_set(input int n, input int pattern);
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] step;
    bit                 down;
    int                 chunk_left;
    int                 i;
    base       = $urandom;
    step       = $urandom_range(0, 1000);
    down       = $urandom_range(0, 1);
    chunk_left = $urandom_range(1, 12);
    v          = base;
    for (i = 0; i < n; i++) begin
      case (pattern)
        PAT_ASCEND: v = base + i * step;
        PAT_DESCND: v = base - i * step;
        PAT_FEWVAL: v = $urandom_range(0, 4) - 2;
        PAT_CHUNKS: begin
          // alternating ascending and descending stretches make natural runs
          if (chunk_left == 0) begin
            down       = !down;
            chunk_left = $urandom_range(1, 12);
          end
          chunk_left--;
          v = down ? v - $urandom_range(0, 50) : v + $urandom_range(0, 50);
        end
        default:    v = $urandom;
      endcase
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = VAL_ZERO;
          default: v = VAL_NEG1;
        endcase
      end
      push_value(v, i == n - 1);
    end
  endtask

  task automatic send_random_set();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = $urandom_range(1, 8);
      4, 5, 6:    n = $urandom_range(9, 32);
      7, 8:       n = $urandom_range(33, 63);
      default:    n = $urandom_range(64, 72);
    endcase
    send_set(n, $urandom_range(PAT_RANDOM, PAT_CHUNKS));
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    int hold_left;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (long_hold) begin
        long_hold = 1'b0;
        hold_left = LONG_HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 6) == 0) begin
        hold_left = $urandom_range(0, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single value at the negative extreme
    push_value(VAL_MIN, 1'b1);
    // both extremes, out of order
    push_value(VAL_MAX, 1'b0);
    push_value(VAL_MIN, 1'b1);
    // duplicates around zero plus extremes
    push_value(VAL_ZERO, 1'b0);
    push_value(VAL_NEG1, 1'b0);
    push_value(32'd1,    1'b0);
    push_value(VAL_MIN,  1'b0);
    push_value(VAL_MAX,  1'b0);
    push_value(VAL_ZERO, 1'b1);
    // all equal
    push_value(32'd5, 1'b0);
    push_value(32'd5, 1'b0);
    push_value(32'd5, 1'b1);
    // strictly descending
    for (int i = 6; i >= 1; i--) push_value(i, i == 1);

    while (items_sent < 80) send_random_set();

    // long receiver hold while the sender keeps offering a full and an overflowing set
    gaps_on   = 1'b0;
    long_hold = 1'b1;
    send_set(64, PAT_CHUNKS);
    send_set(70, PAT_RANDOM);
    gaps_on   = 1'b1;

    // sender pauses until every sorted beat is out
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    while (items_sent < 230) send_random_set();

    // closing stretch with no idling on either side
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (items_sent < 310) send_random_set();

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
